FILE: rtl/core/skbs_pkg.sv
// shared types and constants for the sorted key binary search block
// no dependencies; imported by skbs_key_store, skbs_key_cmp and the top level
package skbs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BYTES   = 16;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int BOUND_W = ADDR_W + 1;
    localparam int KEY_W   = 128;
    localparam int HALF_W  = 64;

    localparam int SLOT_W      = 6;
    localparam int POSITION_W  = 6;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [BOUND_W-1:0]     bound_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_ENTRY_COUNT = 2'd0;
    localparam cfg_index_t REG_CASE_FOLD   = 2'd1;

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // compare outcome
    typedef logic [1:0] cmp_t;
    localparam cmp_t CMP_LT = 2'd0;
    localparam cmp_t CMP_EQ = 2'd1;
    localparam cmp_t CMP_GT = 2'd2;

endpackage

FILE: rtl/core/skbs_key_store.sv
// key table: one write port, one read port with registered read data
// depends on skbs_pkg
module skbs_key_store (
    input  logic           clk,
    input  logic           wr_en,
    input  skbs_pkg::addr_t wr_addr,
    input  skbs_pkg::key_t  wr_data,
    input  logic           rd_en,
    input  skbs_pkg::addr_t rd_addr,
    output skbs_pkg::key_t  rd_data
);
    import skbs_pkg::*;

    key_t mem [TABLE_DEPTH];
    key_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/skbs_key_cmp.sv
// lexicographic compare of two zero-padded keys, optional ascii case fold
// depends on skbs_pkg
module skbs_key_cmp (
    input  skbs_pkg::key_t key_a,
    input  skbs_pkg::key_t key_b,
    input  logic           case_fold,
    output skbs_pkg::cmp_t result
);
    import skbs_pkg::*;

    logic [7:0] byte_a [KEY_BYTES];
    logic [7:0] byte_b [KEY_BYTES];

    // per-byte fold, independent lanes
    always_comb
    begin
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            byte_a[i] = key_a[KEY_W-1-8*i -: 8];
            byte_b[i] = key_b[KEY_W-1-8*i -: 8];
            if (case_fold && byte_a[i] >= 8'h41 && byte_a[i] <= 8'h5a)
            begin
                byte_a[i] = byte_a[i] + 8'h20;
            end
            if (case_fold && byte_b[i] >= 8'h41 && byte_b[i] <= 8'h5a)
            begin
                byte_b[i] = byte_b[i] + 8'h20;
            end
        end
    end

    // first differing byte decides; a shared zero byte ends the string
    always_comb
    begin
        logic stop;
        stop   = 1'b0;
        result = CMP_EQ;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (!stop)
            begin
                if (byte_a[i] != byte_b[i])
                begin
                    result = (byte_a[i] < byte_b[i]) ? CMP_LT : CMP_GT;
                    stop   = 1'b1;
                end
                else if (byte_a[i] == 8'h00)
                begin
                    stop = 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/sorted_key_binary_search.sv
// top level: binary search over a table of sorted 16-byte keys
// depends on skbs_pkg, skbs_key_store, skbs_key_cmp
//
// channel   direction  handshake                 payload
// --------  ---------  ------------------------  ------------------------------------
// request   in         start & !busy             opcode, slot, key_high, key_low
// result    out        done (one-cycle strobe)   found, position
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// a load request writes its slot at the accepting edge; busy stays low, so a
// request can follow in the next cycle
// a search issues one table read per cycle and is busy while it probes;
// done strobes in the first cycle with busy low, and the next request can be taken
// in that same cycle (at most 7 probes for 64 entries; an empty interval gives done
// without raising busy)
// the probe loop is bound by the single read port with registered read data
// rst_n clears control and config state; the key table has no reset
// results cannot be stalled; cfg_ready is always high
module sorted_key_binary_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [skbs_pkg::SLOT_W-1:0]   slot,
    input  logic [skbs_pkg::HALF_W-1:0]   key_high,
    input  logic [skbs_pkg::HALF_W-1:0]   key_low,
    output logic                          done,
    output logic                          found,
    output logic [skbs_pkg::POSITION_W-1:0] position,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  skbs_pkg::cfg_index_t          cfg_index,
    input  logic [skbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import skbs_pkg::*;

    // search sequencer states
    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_COMPARE = 1'b1;

    logic state_reg, state_next;

    // configuration registers
    logic [COUNT_W-1:0] entry_count_reg;
    logic               case_fold_reg;

    // search interval and probe
    bound_t lo_reg, lo_next;
    bound_t hi_reg, hi_next;
    addr_t  mid_reg, mid_next;
    key_t   key_reg;

    // result registers
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [POSITION_W-1:0] position_reg, position_next;

    // memory ports
    logic  wr_en;
    addr_t wr_addr;
    logic  rd_en;
    addr_t rd_addr;
    key_t  rd_data;
    cmp_t  cmp_result;

    logic   accept;
    bound_t count_bound;
    bound_t lo_cand;
    bound_t hi_cand;
    logic [BOUND_W:0] mid_sum;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);

    // the search bound is entry_count saturated at the table depth
    always_comb
    begin
        if (32'(entry_count_reg) > 32'(TABLE_DEPTH))
        begin
            count_bound = BOUND_W'(TABLE_DEPTH);
        end
        else
        begin
            count_bound = BOUND_W'(entry_count_reg);
        end
    end

    // loads go straight into the table; slots past the depth are dropped
    assign wr_en   = accept && (opcode == OP_LOAD) && (32'(slot) < 32'(TABLE_DEPTH));
    assign wr_addr = ADDR_W'(slot);

    skbs_key_store u_key_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({key_high, key_low}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skbs_key_cmp u_key_cmp (
        .key_a     (key_reg),
        .key_b     (rd_data),
        .case_fold (case_fold_reg),
        .result    (cmp_result)
    );

    // narrowed interval after the current compare, or the full interval when idle
    always_comb
    begin
        lo_cand = lo_reg;
        hi_cand = hi_reg;
        if (state_reg == ST_IDLE)
        begin
            lo_cand = '0;
            hi_cand = count_bound;
        end
        else if (cmp_result == CMP_LT)
        begin
            hi_cand = BOUND_W'(mid_reg);
        end
        else if (cmp_result == CMP_GT)
        begin
            lo_cand = BOUND_W'(mid_reg) + BOUND_W'(1);
        end
    end

    assign mid_sum = (BOUND_W+1)'(lo_cand) + (BOUND_W+1)'(hi_cand);

    // sequencer: each cycle in compare consumes one read and may issue the next
    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;
        rd_en         = 1'b0;
        rd_addr       = ADDR_W'(mid_sum >> 1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_SEARCH))
                begin
                    lo_next = lo_cand;
                    hi_next = hi_cand;
                    if (lo_cand < hi_cand)
                    begin
                        rd_en      = 1'b1;
                        mid_next   = rd_addr;
                        state_next = ST_COMPARE;
                    end
                    else
                    begin
                        // empty table
                        done_next     = 1'b1;
                        found_next    = 1'b0;
                        position_next = '0;
                    end
                end
            end
            ST_COMPARE:
            begin
                if (cmp_result == CMP_EQ)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = POSITION_W'(mid_reg);
                    state_next    = ST_IDLE;
                end
                else if (lo_cand < hi_cand)
                begin
                    lo_next  = lo_cand;
                    hi_next  = hi_cand;
                    rd_en    = 1'b1;
                    mid_next = rd_addr;
                end
                else
                begin
                    // interval emptied
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    position_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            entry_count_reg <= '0;
            case_fold_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENTRY_COUNT)
                begin
                    entry_count_reg <= COUNT_W'(cfg_data);
                end
                else if (cfg_index == REG_CASE_FOLD)
                begin
                    case_fold_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        if (accept)
        begin
            key_reg <= {key_high, key_low};
        end
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

FILE: bench/sorted_key_binary_search_tb.sv
// self-checking bench for sorted_key_binary_search: loads sorted key tables, runs searches
// against a cycle-free predictor of the probe sequence; depends on skbs_pkg and the top level
`timescale 1ns / 1ps

module sorted_key_binary_search_tb;
    import skbs_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int ITEM_TARGET   = 1450;
    // a search makes at most 7 probes, done comes as busy falls
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 1000;

    // indexes past the register list, writes there must be ignored
    localparam cfg_index_t REG_SPARE_LO = 2'd2;
    localparam cfg_index_t REG_SPARE_HI = 2'd3;

    typedef struct {
        logic                 op;
        logic [SLOT_W-1:0]    slot;
        key_t                 key;
    } request_t;

    typedef struct {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } search_result_t;

    // dut ports, every input known from time zero
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic                    opcode    = OP_LOAD;
    logic [SLOT_W-1:0]       slot      = '0;
    logic [HALF_W-1:0]       key_high  = '0;
    logic [HALF_W-1:0]       key_low   = '0;
    logic                    done;
    logic                    found;
    logic [POSITION_W-1:0]   position;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    cfg_index_t              cfg_index = REG_ENTRY_COUNT;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // predictor state: key image of the table plus the two registers
    key_t                    key_image [TABLE_DEPTH];
    logic [COUNT_W-1:0]      count_setting = '0;
    logic                    fold_setting  = 1'b0;

    request_t                request_q [$];
    search_result_t          search_results_q [$];
    request_t                active_req;
    key_t                    round_keys [$];

    int unsigned             sender_idle_pct = 0;
    int unsigned             idle_profile [4] = '{0, 61, 0, 22};
    int                      queued_items = 0;
    int                      error_count  = 0;
    int                      quiet_cycles = 0;

    sorted_key_binary_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .slot      (slot),
        .key_high  (key_high),
        .key_low   (key_low),
        .done      (done),
        .found     (found),
        .position  (position),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------
    // key helpers and predictor
    // ---------------------------------------------------------------

    // ascii upper case folds down only when the fold bit is set
    function automatic logic [7:0] fold_letter(logic [7:0] c, logic fold);
        return (fold && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // -1 / 0 / 1 as a orders before, equal to, after b
    // stops at first differing byte or where both strings end
    function automatic int key_order(key_t a, key_t b, logic fold);
        logic [7:0] x;
        logic [7:0] y;
        int         verdict;
        bit         settled;
        verdict = 0;
        settled = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (!settled)
            begin
                x = fold_letter(a[KEY_W-1-8*i -: 8], fold);
                y = fold_letter(b[KEY_W-1-8*i -: 8], fold);
                if (x != y)
                begin
                    verdict = (x < y) ? -1 : 1;
                    settled = 1'b1;
                end
                else if (x == 8'h00)
                    settled = 1'b1;
            end
        end
        return verdict;
    endfunction

    // walks the same midpoint sequence as the block; first equal probe wins
    function automatic search_result_t predict_search(key_t k);
        search_result_t res;
        int             lo;
        int             hi;
        int             mid;
        int             c;
        bit             hit;
        res.found    = 1'b0;
        res.position = '0;
        hit = 1'b0;
        lo  = 0;
        hi  = (int'(count_setting) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
        while (lo < hi && !hit)
        begin
            mid = (lo + hi) / 2;
            c   = key_order(k, key_image[mid], fold_setting);
            if (c < 0)
                hi = mid;
            else if (c > 0)
                lo = mid + 1;
            else
            begin
                hit          = 1'b1;
                res.found    = 1'b1;
                res.position = POSITION_W'(mid);
            end
        end
        return res;
    endfunction

    function automatic key_t text_key(string s);
        key_t k;
        k = '0;
        for (int i = 0; i < s.len() && i < KEY_BYTES; i++)
            k[KEY_W-1-8*i -: 8] = s[i];
        return k;
    endfunction

    // small alphabet so that duplicates, prefixes and case twins are common
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'(8'h61 + $urandom_range(0, 3));
            4, 5:       return 8'(8'h41 + $urandom_range(0, 3));
            6:
            begin
                // letters at the fold edges and their neighbors
                case ($urandom_range(0, 7))
                    0:       return 8'h40;
                    1:       return 8'h41;
                    2:       return 8'h5A;
                    3:       return 8'h5B;
                    4:       return 8'h60;
                    5:       return 8'h61;
                    6:       return 8'h7A;
                    default: return 8'h7B;
                endcase
            end
            7:       return 8'(8'h80 + $urandom_range(0, 127));
            8:       return 8'($urandom_range(1, 8'h3F));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic key_t make_key();
        key_t k;
        int   len;
        k   = '0;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_BYTES) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
            k[KEY_W-1-8*i -: 8] = pick_char();
        return k;
    endfunction

    // garbage after the string end must not change the compare
    function automatic key_t scramble_tail(key_t k);
        int stop_at;
        stop_at = KEY_BYTES;
        for (int i = KEY_BYTES - 1; i >= 0; i--)
            if (k[KEY_W-1-8*i -: 8] == 8'h00)
                stop_at = i;
        for (int i = stop_at + 1; i < KEY_BYTES; i++)
            k[KEY_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
        return k;
    endfunction

    // search key drawn from the current table: exact hits, case twins,
    // tail garbage, near misses and plain noise
    function automatic key_t probe_key();
        key_t k;
        int   roll;
        int   at;
        k    = round_keys[$urandom_range(0, round_keys.size() - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            for (int i = 0; i < KEY_BYTES; i++)
                if (((k[KEY_W-1-8*i -: 8] >= 8'h41 && k[KEY_W-1-8*i -: 8] <= 8'h5A) ||
                     (k[KEY_W-1-8*i -: 8] >= 8'h61 && k[KEY_W-1-8*i -: 8] <= 8'h7A)) &&
                    $urandom_range(0, 1))
                    k[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8] ^ 8'h20;
        end
        else if (roll < 25)
            k = scramble_tail(k);
        else if (roll < 40)
        begin
            at = $urandom_range(0, 3);
            k[KEY_W-1-8*at -: 8] = k[KEY_W-1-8*at -: 8] + ($urandom_range(0, 1) ? 8'h01 : 8'hFF);
        end
        else if (roll < 45)
            k = make_key();
        else if (roll < 50)
            k = {$urandom, $urandom, $urandom, $urandom};
        return k;
    endfunction

    task automatic sort_round_keys(logic fold);
        key_t pick;
        int   j;
        for (int i = 1; i < round_keys.size(); i++)
        begin
            pick = round_keys[i];
            j    = i - 1;
            while (j >= 0 && key_order(round_keys[j], pick, fold) > 0)
            begin
                round_keys[j+1] = round_keys[j];
                j--;
            end
            round_keys[j+1] = pick;
        end
    endtask

    task automatic queue_request(logic op, logic [SLOT_W-1:0] where, key_t k);
        request_t r;
        r.op   = op;
        r.slot = where;
        r.key  = k;
        request_q.push_back(r);
        queued_items++;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // register writes and phase boundaries
    // ---------------------------------------------------------------

    // only called with no request in flight and nothing outstanding
    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ENTRY_COUNT)
            count_setting = value;
        else if (idx == REG_CASE_FOLD)
            fold_setting = value[0];
    endtask

    // everything sent, every result back, then let the block settle
    task automatic wait_for_idle();
        while (request_q.size() != 0 || start || search_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one phase: a freshly sorted table, register settings, then searches
    task automatic run_round(int idx);
        int                    n;
        int                    m;
        int                    count;
        int                    j;
        int                    tmp;
        int                    order [TABLE_DEPTH];
        logic                  fold;
        logic [CFG_DATA_W-1:0] fold_word;
        fold = 1'($urandom_range(0, 1));
        // first round fills the whole table so every slot is written from then on
        if (idx == 0 || $urandom_range(0, 9) == 0)
            n = TABLE_DEPTH;
        else if ($urandom_range(0, 9) == 0)
            n = 1;
        else
            n = $urandom_range(2, 24);
        round_keys.delete();
        for (int i = 0; i < n; i++)
            round_keys.push_back(make_key());
        sort_round_keys(fold);

        // mostly the loaded size; sometimes fewer, sometimes reaching into stale slots
        case ($urandom_range(0, 9))
            0:       count = $urandom_range(0, n);
            1:       count = $urandom_range(n, TABLE_DEPTH);
            default: count = n;
        endcase
        // counts past the table depth saturate
        if (idx == 0)
            count = 127;
        else if (n == TABLE_DEPTH && $urandom_range(0, 3) == 0)
            count = $urandom_range(TABLE_DEPTH, 127);

        wait_for_idle();
        sender_idle_pct = idle_profile[(idx / 3) % 4];
        write_register(REG_ENTRY_COUNT, CFG_DATA_W'(count));
        // upper data bits are don't care for the fold register
        fold_word    = CFG_DATA_W'($urandom);
        fold_word[0] = fold;
        write_register(REG_CASE_FOLD, fold_word);
        if (idx == 0 || $urandom_range(0, 7) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                           CFG_DATA_W'($urandom));

        // loads in shuffled slot order
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            queue_request(OP_LOAD, SLOT_W'(order[i]), round_keys[order[i]]);

        // searches, with the odd stray load that may break the ordering
        m = $urandom_range(6, 20);
        for (int i = 0; i < m; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                queue_request(OP_LOAD, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), make_key());
            queue_request(OP_SEARCH, SLOT_W'($urandom), probe_key());
        end
    endtask

    // ---------------------------------------------------------------
    // request driver: pops the pending queue, may idle between requests
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : request_driver
        search_result_t res;
        if (rst_n)
        begin
            // request taken at this edge: update the key image or predict the result
            if (start && !busy)
            begin
                if (active_req.op == OP_LOAD)
                    key_image[active_req.slot] = active_req.key;
                else
                begin
                    res = predict_search(active_req.key);
                    search_results_q.push_back(res);
                end
            end
            // hold a waiting request; otherwise present the next one or idle
            if (!(start && busy))
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    active_req = request_q.pop_front();
                    start    <= 1'b1;
                    opcode   <= active_req.op;
                    slot     <= active_req.slot;
                    key_high <= active_req.key[KEY_W-1 -: HALF_W];
                    key_low  <= active_req.key[HALF_W-1:0];
                end
                else
                begin
                    // payload is don't care while start is low
                    start    <= 1'b0;
                    opcode   <= 1'($urandom_range(0, 1));
                    slot     <= SLOT_W'($urandom);
                    key_high <= {$urandom, $urandom};
                    key_low  <= {$urandom, $urandom};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: one-cycle done strobe, cannot be held off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        search_result_t want;
        if (rst_n && done)
        begin
            if (search_results_q.size() == 0)
                report_mismatch("result with no search outstanding", 64'({found, position}), '0);
            else
            begin
                want = search_results_q.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 64'(found), 64'(want.found));
                if (position !== want.position)
                    report_mismatch("position", 64'(position), 64'(want.position));
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long with no request, result or register write
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : progress_watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("sorted_key_binary_search_tb NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus: directed corners first, then random rounds
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int round_idx;
        round_idx = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: nothing to probe, must miss at position zero
        sender_idle_pct = 0;
        write_register(REG_ENTRY_COUNT, 7'd0);
        queue_request(OP_SEARCH, 6'd0, '0);
        queue_request(OP_SEARCH, 6'd63, '1);

        // small table ordered for exact compare: empty string, case twins, all ones
        queue_request(OP_LOAD, 6'd2, text_key("apple"));
        queue_request(OP_LOAD, 6'd0, text_key(""));
        queue_request(OP_LOAD, 6'd3, '1);
        queue_request(OP_LOAD, 6'd1, text_key("Apple"));
        queue_request(OP_LOAD, 6'd63, '1);
        wait_for_idle();
        write_register(REG_ENTRY_COUNT, 7'd4);
        write_register(REG_CASE_FOLD, 7'h7E);

        queue_request(OP_SEARCH, 6'd0, text_key(""));
        queue_request(OP_SEARCH, 6'd0, scramble_tail(text_key("")));
        queue_request(OP_SEARCH, 6'd0, text_key("Apple"));
        queue_request(OP_SEARCH, 6'd0, text_key("apple"));
        queue_request(OP_SEARCH, 6'd0, scramble_tail(text_key("apple")));
        queue_request(OP_SEARCH, 6'd0, '1);
        queue_request(OP_SEARCH, 6'd0, text_key("appl"));
        queue_request(OP_SEARCH, 6'd0, text_key("applf"));
        queue_request(OP_SEARCH, 6'd0, text_key("APPLE"));
        wait_for_idle();

        // fold on: the twins become duplicates, '@' sits just below 'A'
        write_register(REG_CASE_FOLD, 7'h7F);
        queue_request(OP_SEARCH, 6'd0, text_key("APPLE"));
        queue_request(OP_SEARCH, 6'd0, text_key("ApPlE"));
        queue_request(OP_SEARCH, 6'd0, text_key("@pple"));

        // random rounds until enough requests have gone in
        while (queued_items < ITEM_TARGET)
        begin
            run_round(round_idx);
            round_idx++;
        end
        wait_for_idle();

        if (error_count == 0)
            $display("sorted_key_binary_search_tb OK");
        else
            $display("sorted_key_binary_search_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/skbs_pkg.sv
rtl/core/skbs_key_store.sv
rtl/core/skbs_key_cmp.sv
rtl/core/sorted_key_binary_search.sv
bench/sorted_key_binary_search_tb.sv
